>>> hdl/sul_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types and constants for the static unordered list core: request and
// response words, opcodes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package sul_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int OP_W         = 2;
  localparam int CAPACITY_DEF = 64;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EXISTS = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_GET,
    ST_GET_WAIT,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  // Request word
  typedef struct packed {
    logic        [OP_W-1:0]   opcode;
    logic signed [DATA_W-1:0] value;
    logic        [IDX_W-1:0]  index;
  } req_t;

  // Response word
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic        [COUNT_W-1:0] count;
    logic                     empty_res;
    logic                     full_res;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;        // latch request, clear result and scan pointer
    logic ins;          // append value, bump count
    logic get_rd;       // read entry at request index
    logic get_ld;       // capture read entry as result data
    logic step;         // issue next scan/shift read
    logic shift_start;  // match found: restart pointer after match
    logic shift_wr;     // write previous read one slot toward the front
    logic found;        // exists hit
    logic dec;          // drop count after compaction
    logic load_out;     // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_room;
    logic idx_ok;
    logic match;
    logic exhausted;
    logic is_remove;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/sul_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sul_ctrl
// Controller state machine: sequences insert, get, search and compaction
// through the datapath and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module sul_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [sul_pkg::OP_W-1:0]   op,
  output logic                       req_stall,
  input  sul_pkg::status_t           status,
  output sul_pkg::cmd_t              cmd
);
  import sul_pkg::*;

  state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          case (op_e'(op))
            OP_INSERT: state_next = ST_INS;
            OP_GET:    state_next = ST_GET;
            default:   state_next = ST_SCAN;
          endcase
        end
      end
      ST_INS: begin
        cmd.ins    = status.has_room;
        state_next = ST_FINISH;
      end
      ST_GET: begin
        if (status.idx_ok) begin
          cmd.get_rd = 1'b1;
          state_next = ST_GET_WAIT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_GET_WAIT: begin
        cmd.get_ld = 1'b1;
        state_next = ST_FINISH;
      end
      // linear search, one entry compared per cycle
      ST_SCAN: begin
        if (status.match) begin
          if (status.is_remove) begin
            cmd.shift_start = 1'b1;
            state_next      = ST_SHIFT;
          end else begin
            cmd.found  = 1'b1;
            state_next = ST_FINISH;
          end
        end else if (status.exhausted) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      // compaction: read entry i, then write the registered read to i-1
      ST_SHIFT: begin
        if (status.exhausted) begin
          cmd.dec    = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/sul_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sul_datapath
// Entry memory, count, scan pointer with compare stage, result capture and
// the output register.
// ----------------------------------------------------------------------------
module sul_datapath #(
  parameter int CAPACITY = sul_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sul_pkg::req_t     req,
  input  sul_pkg::cmd_t     cmd,
  output sul_pkg::status_t  status,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output sul_pkg::rsp_t     rsp
);
  import sul_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  pv_addr;
  logic              pv;

  req_t              req_q;
  logic              res_ok;
  logic [DATA_W-1:0] res_data;

  logic              rd_more;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Memory port selection
  assign rd_more = (rd_ptr < used);
  assign rd_en   = cmd.get_rd | (cmd.step & rd_more);
  assign rd_addr = cmd.get_rd ? AW'(req_q.index) : AW'(rd_ptr);
  assign wr_en   = cmd.ins | (cmd.shift_wr & pv);
  assign wr_addr = cmd.ins ? AW'(used) : AW'(pv_addr - CNT_W'(1));
  assign wr_data = cmd.ins ? req_q.value : rd_data;

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Count, scan pointer and compare-stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_ptr  <= '0;
      pv_addr <= '0;
      pv      <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_ptr <= '0;
        pv     <= 1'b0;
      end else if (cmd.shift_start) begin
        rd_ptr <= pv_addr + CNT_W'(1);
        pv     <= 1'b0;
      end else if (cmd.step) begin
        pv      <= rd_more;
        pv_addr <= rd_ptr;
        if (rd_more) begin
          rd_ptr <= rd_ptr + CNT_W'(1);
        end
      end
      if (cmd.ins) begin
        used <= used + CNT_W'(1);
      end else if (cmd.dec) begin
        used <= used - CNT_W'(1);
      end
    end
  end

  // Request latch and result capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q    <= req;
      res_ok   <= 1'b0;
      res_data <= '0;
    end else begin
      if (cmd.ins | cmd.found | cmd.shift_start | cmd.get_ld) begin
        res_ok <= 1'b1;
      end
      if (cmd.get_ld) begin
        res_data <= rd_data;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.ok        <= res_ok;
      rsp.data      <= res_data;
      rsp.count     <= COUNT_W'(used);
      rsp.empty_res <= (used == '0);
      rsp.full_res  <= (used == CNT_W'(CAPACITY));
    end
  end

  // Status to controller
  always_comb begin
    status.has_room  = (used < CNT_W'(CAPACITY));
    status.idx_ok    = (CMP_W'(req_q.index) < CMP_W'(used));
    status.match     = pv & (rd_data == req_q.value);
    status.exhausted = ~pv & ~rd_more;
    status.is_remove = (req_q.opcode == OP_REMOVE);
    status.out_free  = ~rsp_valid | ~rsp_stall;
  end

endmodule
`default_nettype wire

>>> hdl/static_unordered_list_core.sv
`default_nettype none
// Exists and remove scan from the front of the list, one stored entry compared
// per cycle on the memory read port; remove then copies each later entry once.
// One word is in flight at a time; the next is taken once the result sits in
// the output register, so a new word waits behind the previous result and any
// output stall.
// Reset (synchronous) empties the list; entry contents are left as they are.
// ----------------------------------------------------------------------------
// static_unordered_list_core
// Fixed-capacity list of signed values packed in insertion order, with
// insert, remove-first-match, exists and get-by-index requests.
// ----------------------------------------------------------------------------
module static_unordered_list_core #(
  parameter int CAPACITY = sul_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sul_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sul_pkg::rsp_t rsp
);
  import sul_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  sul_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (req.opcode),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and result path
  sul_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
